FILE: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// S-box table, field helpers and shared types for the AES-128 encrypt engine.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int BLOCK_W  = 128;
    localparam int HALF_W   = 64;
    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [7:0]         byte_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [3:0]         round_t;

    function automatic byte_t sbox(input byte_t a);
        byte_t r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits 127-8i : 120-8i.
    function automatic byte_t get_byte(input block_t b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    // Round constant for the key step that produces round key r (1..10).
    function automatic byte_t rcon(input round_t r);
        byte_t c;
        case (r)
            4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
            4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
            4'd9: c = 8'h1b; 4'd10: c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/aes_stream_if.sv
// ----------------------------------------------------------------------------
// AES stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source  (output valid, output data_high, output data_low, input ready);
    modport sink    (input valid, input data_high, input data_low, output ready);
    modport monitor (input valid, input data_high, input data_low, input ready);
endinterface

`default_nettype wire

FILE: src/aes_cfg_if.sv
// ----------------------------------------------------------------------------
// AES configuration interface
// Register write channel: index and data under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;

    modport source  (output valid, output index, output data, input ready);
    modport sink    (input valid, input index, input data, output ready);
    modport monitor (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

FILE: src/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Round-pipelined AES-128 encryption, one cell per round.
// ----------------------------------------------------------------------------
// Pipeline: key-add register plus ten round cells between input transaction
// and result valid. Throughput: one block per cycle, set by the ten-cell
// round chain that advances whenever the output can move.
// Reset: clears all valid bits and both key registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt (
    input  wire logic     clk,
    input  wire logic     rst_n,
    aes_cfg_if.sink       cfg,
    aes_stream_if.sink    plain,
    aes_stream_if.source  cipher
);
    import aes_pkg::*;

    // Key registers; configuration is always accepted.
    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_KEY_HIGH: key_high_reg <= cfg.data;
                REG_KEY_LOW:  key_low_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // The whole chain moves together; it stalls only when the last cell
    // holds a result that the sink has not taken. The last cell is the
    // output register, so new data enters only when that slot is empty or taken;
    logic advance;
    assign advance = !cipher.valid || cipher.ready;
    assign plain.ready = advance;

    // Stage 0: initial round-key add; carry the key with the data.
    logic   v0_reg;
    block_t s0_reg;
    block_t k0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= plain.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= {plain.data_high, plain.data_low} ^ {key_high_reg, key_low_reg};
            k0_reg <= {key_high_reg, key_low_reg};
        end
    end

    // Chain of round cells.
    logic   v [NUM_ROUNDS+1];
    block_t s [NUM_ROUNDS+1];
    block_t k [NUM_ROUNDS+1];

    assign v[0] = v0_reg;
    assign s[0] = s0_reg;
    assign k[0] = k0_reg;

    for (genvar g = 1; g <= NUM_ROUNDS; g++)
    begin : g_round
        aes_round_cell #(.ROUND(4'(g))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (v[g-1]),
            .state_in  (s[g-1]),
            .key_in    (k[g-1]),
            .valid_out (v[g]),
            .state_out (s[g]),
            .key_out   (k[g])
        );
    end

    // Last cell's register drives the output; its key copy goes unused downstream.
    logic unused_key;
    assign unused_key = ^k[NUM_ROUNDS];

    assign cipher.valid     = v[NUM_ROUNDS];
    assign cipher.data_high = s[NUM_ROUNDS][BLOCK_W-1:HALF_W];
    assign cipher.data_low  = s[NUM_ROUNDS][HALF_W-1:0];
endmodule

`default_nettype wire

FILE: src/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES round cell
// One pipeline cell: a cipher round and the matching key-schedule step.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            valid_in,
    input  wire aes_pkg::block_t state_in,
    input  wire aes_pkg::block_t key_in,
    output logic                 valid_out,
    output aes_pkg::block_t      state_out,
    output aes_pkg::block_t      key_out
);
    import aes_pkg::*;

    block_t key_next;
    block_t state_next;
    byte_t  t [4];
    byte_t  s [16];

    // key schedule step
    always_comb
    begin
        t[0] = sbox(get_byte(key_in, 13)) ^ rcon(ROUND);
        t[1] = sbox(get_byte(key_in, 14));
        t[2] = sbox(get_byte(key_in, 15));
        t[3] = sbox(get_byte(key_in, 12));
        for (int w = 0; w < 4; w++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (w == 0)
                    key_next[BLOCK_W-1-8*j -: 8] = get_byte(key_in, j) ^ t[j];
                else
                    key_next[BLOCK_W-1-8*(4*w+j) -: 8] =
                        get_byte(key_in, 4*w+j) ^ key_next[BLOCK_W-1-8*(4*(w-1)+j) -: 8];
            end
        end
    end

    // substitution, row shift, column mix (all but the final round), key add
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[r+4*c] = sbox(get_byte(state_in, r + 4*((c + r) % 4)));
        for (int c = 0; c < 4; c++)
        begin
            if (ROUND == 4'(NUM_ROUNDS))
            begin
                for (int r = 0; r < 4; r++)
                    state_next[BLOCK_W-1-8*(4*c+r) -: 8] = s[4*c+r];
            end
            else
            begin
                state_next[BLOCK_W-1-8*(4*c)   -: 8] = xtime(s[4*c]) ^ xtime(s[4*c+1])
                    ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
                state_next[BLOCK_W-1-8*(4*c+1) -: 8] = s[4*c] ^ xtime(s[4*c+1])
                    ^ xtime(s[4*c+2]) ^ s[4*c+2] ^ s[4*c+3];
                state_next[BLOCK_W-1-8*(4*c+2) -: 8] = s[4*c] ^ s[4*c+1]
                    ^ xtime(s[4*c+2]) ^ xtime(s[4*c+3]) ^ s[4*c+3];
                state_next[BLOCK_W-1-8*(4*c+3) -: 8] = xtime(s[4*c]) ^ s[4*c]
                    ^ s[4*c+1] ^ s[4*c+2] ^ xtime(s[4*c+3]);
            end
        end
        state_next = state_next ^ key_next;
    end

    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
endmodule

`default_nettype wire
